### design/bbr_pkg.sv
// Shared constants and arctangent table for the baseline range and bearing core.
// No dependencies.
package bbr_pkg;

  localparam int PIPE_DEPTH   = 35;   // stages from item in to output register
  localparam int ATAN_ENTRIES = 24;
  localparam int NORM_PRE     = 9;    // fixed left shift ahead of the normaliser
  localparam int CW           = 45;   // CORDIC datapath width

  localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [31:0] ROUND_HALF = 32'h0000_8000;
  localparam logic [15:0] ZERO_TRACK = 16'h8000;

  // floor(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [31:0] atan_of(input int idx);
    logic [31:0] a;
    case (idx)
      0:       a = 32'h2000_0000;
      1:       a = 32'h12E4_051D;
      2:       a = 32'h09FB_385B;
      3:       a = 32'h0511_11D4;
      4:       a = 32'h028B_0D43;
      5:       a = 32'h0145_D7E1;
      6:       a = 32'h00A2_F61E;
      7:       a = 32'h0051_7C55;
      8:       a = 32'h0028_BE53;
      9:       a = 32'h0014_5F2E;
      10:      a = 32'h000A_2F98;
      11:      a = 32'h0005_17CC;
      12:      a = 32'h0002_8BE6;
      13:      a = 32'h0001_45F3;
      14:      a = 32'h0000_A2F9;
      15:      a = 32'h0000_517C;
      16:      a = 32'h0000_28BE;
      17:      a = 32'h0000_145F;
      18:      a = 32'h0000_0A2F;
      19:      a = 32'h0000_0517;
      20:      a = 32'h0000_028B;
      21:      a = 32'h0000_0145;
      22:      a = 32'h0000_00A2;
      23:      a = 32'h0000_0051;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

### design/bbr_in_if.sv
// Input channel: one baseline item (east, north, up offsets).
// No dependencies.
interface bbr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] east_mm;
  logic signed [31:0] north_mm;
  logic signed [31:0] up_mm;

  modport source (output valid, output east_mm, output north_mm, output up_mm,
                  input ready);
  modport sink (input valid, input east_mm, input north_mm, input up_mm,
                output ready);
endinterface

### design/bbr_out_if.sv
// Output channel: one result item (range, track, altitude).
// No dependencies.
interface bbr_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] range_mm;
  logic        [15:0] track_angle;
  logic signed [31:0] altitude_mm;

  modport source (output valid, output range_mm, output track_angle, output altitude_mm,
                  input ready);
  modport sink (input valid, input range_mm, input track_angle, input altitude_mm,
                output ready);
endinterface

### design/bbr_isqrt.sv
// Pipelined horizontal range: squares, sum, one root digit per stage, rounding.
// Depends on bbr_pkg.
module bbr_isqrt
  import bbr_pkg::*;
(
  input  logic                  clk,
  input  logic [PIPE_DEPTH-1:0] en,
  input  logic signed [31:0]    east,
  input  logic signed [31:0]    north,
  output logic [31:0]           range_mm
);

  logic [31:0] ae, an;
  logic [63:0] sq_e, sq_n;
  logic [63:0] rem [0:32];
  logic [63:0] res [0:32];

  assign ae = east[31]  ? 32'(-east)  : 32'(east);
  assign an = north[31] ? 32'(-north) : 32'(north);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq_e <= 64'(ae) * 64'(ae);
      sq_n <= 64'(an) * 64'(an);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rem[0] <= sq_e + sq_n;
      res[0] <= '0;
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_digit
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
    logic [63:0] trial;
    assign trial = res[j] + BIT;
    always_ff @(posedge clk) begin
      if (en[2 + j]) begin
        if (rem[j] >= trial) begin
          rem[j+1] <= rem[j] - trial;
          res[j+1] <= (res[j] >> 1) + BIT;
        end else begin
          rem[j+1] <= rem[j];
          res[j+1] <= res[j] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[34]) begin
      range_mm <= res[32][31:0] + 32'(rem[32] > res[32]);
    end
  end

endmodule

### design/bbr_cordic.sv
// Pipelined vectoring CORDIC for the track angle: half-turn fold, normaliser,
// one micro-rotation per stage, rounding, then delay to the common depth.
// Depends on bbr_pkg.
module bbr_cordic
  import bbr_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                  clk,
  input  logic [PIPE_DEPTH-1:0] en,
  input  logic signed [31:0]    east,
  input  logic signed [31:0]    north,
  output logic [15:0]           track
);

  localparam int NS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int DL = PIPE_DEPTH - (6 + NS);

  // fold
  logic signed [32:0] ex, nx, x0, y0, x1, y1;
  logic        [31:0] z0, z1, z2, z3, z4;
  logic               zero0, zero1, zero2, zero3, zero4;
  logic        [32:0] ax1, ay1;
  logic        [31:0] m1;

  assign ex = 33'(east);
  assign nx = 33'(north);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      if (nx[32]) begin
        x0 <= -nx;
        y0 <= -ex;
        z0 <= HALF_TURN;
      end else begin
        x0 <= nx;
        y0 <= ex;
        z0 <= '0;
      end
      zero0 <= (east == 0) && (north == 0);
    end
  end

  assign ax1 = x0[32] ? 33'(-x0) : 33'(x0);
  assign ay1 = y0[32] ? 33'(-y0) : 33'(y0);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x1    <= x0;
      y1    <= y0;
      z1    <= z0;
      zero1 <= zero0;
      m1    <= (ax1 > ay1) ? ax1[31:0] : ay1[31:0];
    end
  end

  // normaliser: bring the larger magnitude's leading one to bit 40
  logic signed [CW-1:0] xa, ya, x2, y2, x2b, y2b, x3, y3, x3b, y3b, x4, y4;
  logic        [40:0]   ma, m2, m2b, m3, m3b;

  assign ma = {m1, 9'b0};
  assign xa = CW'(x1) <<< NORM_PRE;
  assign ya = CW'(y1) <<< NORM_PRE;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (ma[40:25] == '0) begin
        m2 <= ma << 16;
        x2 <= xa <<< 16;
        y2 <= ya <<< 16;
      end else begin
        m2 <= ma;
        x2 <= xa;
        y2 <= ya;
      end
      z2    <= z1;
      zero2 <= zero1;
    end
  end

  always_comb begin
    if (m2[40:33] == '0) begin
      m2b = m2 << 8;
      x2b = x2 <<< 8;
      y2b = y2 <<< 8;
    end else begin
      m2b = m2;
      x2b = x2;
      y2b = y2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (m2b[40:37] == '0) begin
        m3 <= m2b << 4;
        x3 <= x2b <<< 4;
        y3 <= y2b <<< 4;
      end else begin
        m3 <= m2b;
        x3 <= x2b;
        y3 <= y2b;
      end
      z3    <= z2;
      zero3 <= zero2;
    end
  end

  always_comb begin
    if (m3[40:39] == '0) begin
      m3b = m3 << 2;
      x3b = x3 <<< 2;
      y3b = y3 <<< 2;
    end else begin
      m3b = m3;
      x3b = x3;
      y3b = y3;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      if (!m3b[40]) begin
        x4 <= x3b <<< 1;
        y4 <= y3b <<< 1;
      end else begin
        x4 <= x3b;
        y4 <= y3b;
      end
      z4    <= z3;
      zero4 <= zero3;
    end
  end

  // micro-rotations
  logic signed [CW-1:0] cx [0:NS];
  logic signed [CW-1:0] cy [0:NS];
  logic        [31:0]   cz [0:NS];
  logic                 cz0 [0:NS];

  assign cx[0]  = x4;
  assign cy[0]  = y4;
  assign cz[0]  = z4;
  assign cz0[0] = zero4;

  for (genvar i = 0; i < NS; i++) begin : g_rot
    localparam logic [31:0] ATAN = atan_of(i);
    always_ff @(posedge clk) begin
      if (en[5 + i]) begin
        if (!cy[i][CW-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN;
        end
        cz0[i+1] <= cz0[i];
      end
    end
  end

  // rounding to a 16-bit angle
  logic [31:0] zr;
  logic [15:0] trk;
  logic [15:0] trk_d [0:DL-1];

  assign zr = cz[NS] + HALF_TURN + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en[5 + NS]) begin
      trk <= cz0[NS] ? ZERO_TRACK : zr[31:16];
    end
  end

  for (genvar j = 0; j < DL; j++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[6 + NS + j]) begin
        trk_d[j] <= (j == 0) ? trk : trk_d[(j == 0) ? 0 : j - 1];
      end
    end
  end

  assign track = trk_d[DL-1];

endmodule

### design/baseline_range_and_bearing_core.sv
// Baseline range and bearing core: range by pipelined integer square root,
// reversed bearing by pipelined vectoring CORDIC, up offset passed through.
// 35 register stages; one item per cycle while the output keeps taking results.
// Each stage holds when it is full and the stage after it cannot take its item,
// so empty stages keep filling while a result waits at the output register.
// Synchronous active-high reset empties the pipeline; payload is not reset.
module baseline_range_and_bearing_core
  import bbr_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  bbr_in_if.sink      baseline,
  bbr_out_if.source   result
);

  logic [PIPE_DEPTH-1:0] v;
  logic [PIPE_DEPTH:0]   adv;
  logic signed [31:0]    alt [0:PIPE_DEPTH-1];

  always_comb begin
    adv[PIPE_DEPTH] = result.ready;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (adv[k]) begin
          v[k] <= (k == 0) ? baseline.valid : v[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  for (genvar k = 0; k < PIPE_DEPTH; k++) begin : g_alt
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        alt[k] <= (k == 0) ? baseline.up_mm : alt[(k == 0) ? 0 : k - 1];
      end
    end
  end

  bbr_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv[PIPE_DEPTH-1:0]),
    .east     (baseline.east_mm),
    .north    (baseline.north_mm),
    .range_mm (result.range_mm)
  );

  bbr_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk   (clk),
    .en    (adv[PIPE_DEPTH-1:0]),
    .east  (baseline.east_mm),
    .north (baseline.north_mm),
    .track (result.track_angle)
  );

  assign baseline.ready     = adv[0];
  assign result.valid       = v[PIPE_DEPTH-1];
  assign result.altitude_mm = alt[PIPE_DEPTH-1];

endmodule

### tb/baseline_range_and_bearing_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for baseline_range_and_bearing_core: sends east/north/up baselines,
// predicts range, reversed bearing and altitude for each item and checks every result.
// Depends on bbr_pkg, bbr_in_if, bbr_out_if and the core itself.
module baseline_range_and_bearing_core_tb;
  import bbr_pkg::*;

  localparam int STAGES      = 16;
  localparam int CYCLE_LIMIT = 300000;

  localparam logic signed [31:0] OFS_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] OFS_MAX = 32'sh7FFF_FFFF;

  // floor(atan(2^-i) / (2*pi) * 2^32)
  localparam logic [31:0] ARCTAN [24] = '{
    32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
    32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
  };

  typedef struct packed {
    logic        [31:0] range_mm;
    logic        [15:0] track;
    logic signed [31:0] alt;
  } polar_fix_t;

  typedef enum {RX_FREE, RX_RANDOM, RX_COMB, RX_CHOKE} rx_style_t;

  logic clk;
  logic rst;
  logic take = 1'b0;

  polar_fix_t awaited [$];
  int         errors        = 0;
  int         checked       = 0;
  int         accepted      = 0;
  int         zero_count    = 0;
  int         extreme_count = 0;
  int         cycles        = 0;
  int         gap_max       = 0;
  int         burst_max     = 1;
  int         burst_left    = 0;
  rx_style_t  rx_style      = RX_FREE;

  bbr_in_if  base_ch ();
  bbr_out_if fix_ch ();

  baseline_range_and_bearing_core #(.CORDIC_STAGES(STAGES)) dut (
    .clk      (clk),
    .rst      (rst),
    .baseline (base_ch),
    .result   (fix_ch)
  );

  assign fix_ch.ready = take;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] horizontal_range(input logic signed [31:0] e,
                                                   input logic signed [31:0] n);
    longint          se, sn;
    longint unsigned ae, an, sq, root, cand;
    int              b;
    se = e;
    sn = n;
    ae = (se < 0) ? -se : se;
    an = (sn < 0) ? -sn : sn;
    sq = ae * ae + an * an;
    root = 0;
    for (b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= sq) root = cand;
    end
    if (sq - root * root > root) root = root + 1;
    return root[31:0];
  endfunction

  function automatic logic [15:0] reversed_bearing(input logic signed [31:0] e,
                                                   input logic signed [31:0] n);
    longint          x, y, t;
    longint unsigned ax, ay, m;
    logic     [31:0] z;
    int              k, i;
    if (e == 0 && n == 0) return ZERO_TRACK;
    x = n;
    y = e;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HALF_TURN;
    end
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    m = (ax > ay) ? ax : ay;
    k = 0;
    while (m < (64'd1 << 40)) begin
      m = m << 1;
      k++;
    end
    x = x <<< k;
    y = y <<< k;
    for (i = 0; i < STAGES && i < 24; i++) begin
      t = x;
      if (y >= 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z = z + ARCTAN[i];
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z = z - ARCTAN[i];
      end
    end
    z = z + HALF_TURN + ROUND_HALF;
    return z[31:16];
  endfunction

  function automatic logic signed [31:0] pick_offset();
    int                 sel;
    logic signed [31:0] v;
    sel = $urandom_range(0, 9);
    case (sel) inside
      [0:3]:  v = $urandom;
      [4:5]:  v = int'($urandom_range(0, 2000)) - 1000;
      6: begin
        v = 32'sd1 <<< $urandom_range(0, 30);
        if ($urandom_range(0, 1)) v = -v;
      end
      7: begin
        case ($urandom_range(0, 4))
          0:       v = OFS_MIN;
          1:       v = OFS_MAX;
          2:       v = -1;
          3:       v = 1;
          default: v = 0;
        endcase
      end
      8:       v = $signed($urandom) >>> $urandom_range(0, 31);
      default: v = 0;
    endcase
    return v;
  endfunction

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want, checked);
    errors++;
  endtask

  task automatic set_pace(input int gaps, input int burst, input rx_style_t style);
    gap_max   = gaps;
    burst_max = burst;
    rx_style  = style;
  endtask

  // valid stays high after acceptance; anything that lets time pass lowers it first
  task automatic put_baseline(input logic signed [31:0] e, input logic signed [31:0] n,
                              input logic signed [31:0] u);
    polar_fix_t fix;
    if (gap_max > 0 && burst_left == 0) begin
      base_ch.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, burst_max);
    end
    base_ch.valid    <= 1'b1;
    base_ch.east_mm  <= e;
    base_ch.north_mm <= n;
    base_ch.up_mm    <= u;
    @(posedge clk);
    while (base_ch.ready !== 1'b1) @(posedge clk);
    if (burst_left > 0) burst_left--;
    fix.range_mm = horizontal_range(e, n);
    fix.track    = reversed_bearing(e, n);
    fix.alt      = u;
    awaited.push_back(fix);
    accepted++;
    if (e == 0 && n == 0) zero_count++;
    if (e == OFS_MIN || n == OFS_MIN || u == OFS_MIN) extreme_count++;
  endtask

  task automatic settle();
    base_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_baselines();
    set_pace(0, 1, RX_FREE);
    put_baseline(0, 0, 0);
    put_baseline(0, 0, OFS_MIN);
    put_baseline(0, 0, OFS_MAX);
    put_baseline(0, 1, 1);
    put_baseline(0, -1, -1);
    put_baseline(1, 0, 7);
    put_baseline(-1, 0, -7);
    put_baseline(OFS_MAX, 0, 0);
    put_baseline(OFS_MIN, 0, 0);
    put_baseline(0, OFS_MAX, 0);
    put_baseline(0, OFS_MIN, 0);
    put_baseline(OFS_MIN, OFS_MIN, OFS_MIN);
    put_baseline(OFS_MAX, OFS_MAX, OFS_MAX);
    put_baseline(OFS_MIN, OFS_MAX, -1);
    put_baseline(OFS_MAX, OFS_MIN, 1);
    put_baseline(1, 1, 0);
    put_baseline(-1, -1, 0);
    put_baseline(1, -1, 0);
    put_baseline(-1, 1, 0);
    put_baseline(3, 4, 12345);
    put_baseline(-3000, 4000, -12345);
    put_baseline(-1, OFS_MIN, 32'sh5555_5555);
    put_baseline(OFS_MIN, -1, 32'shAAAA_AAAA);
  endtask

  task automatic test_full_scale();
    int i;
    set_pace(8, 30, RX_RANDOM);
    for (i = 0; i < 400; i++) put_baseline($urandom, $urandom, $urandom);
  endtask

  task automatic test_small_offsets();
    int i, lim;
    set_pace(4, 12, RX_COMB);
    for (i = 0; i < 250; i++) begin
      case ($urandom_range(0, 2))
        0:       lim = 3;
        1:       lim = 1000;
        default: lim = 65535;
      endcase
      put_baseline(int'($urandom_range(0, 2 * lim)) - lim,
                   int'($urandom_range(0, 2 * lim)) - lim, $urandom);
    end
  endtask

  task automatic test_axes_and_diagonals();
    int                 i;
    logic signed [31:0] m;
    set_pace(12, 20, RX_CHOKE);
    for (i = 0; i < 200; i++) begin
      m = $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 31);
      case ($urandom_range(0, 7))
        0:       put_baseline(m, 0, $urandom);
        1:       put_baseline(0, -m, $urandom);
        2:       put_baseline(-m, 0, $urandom);
        3:       put_baseline(0, m, $urandom);
        4:       put_baseline(m, m, $urandom);
        5:       put_baseline(-m, m + 1, $urandom);
        6:       put_baseline(m, -(m >>> 3), $urandom);
        default: put_baseline(-m, -m, $urandom);
      endcase
    end
  endtask

  task automatic test_back_to_back();
    int i;
    set_pace(0, 1, RX_FREE);
    for (i = 0; i < 300; i++) begin
      if (i == 200) set_pace(0, 1, RX_RANDOM);
      put_baseline(pick_offset(), pick_offset(), $urandom);
    end
  endtask

  task automatic test_mixed();
    int i;
    set_pace(20, 50, RX_RANDOM);
    for (i = 0; i < 250; i++) put_baseline(pick_offset(), pick_offset(), pick_offset());
  endtask

  always @(posedge clk) begin
    case (rx_style)
      RX_FREE:   take <= 1'b1;
      RX_RANDOM: take <= ($urandom_range(0, 99) >= 40);
      RX_COMB:   take <= ((cycles % 11) < 6);
      default:   take <= ((cycles % 9) == 0);
    endcase
  end

  always @(posedge clk) begin : check_fixes
    polar_fix_t want;
    if (!rst && fix_ch.valid === 1'b1 && fix_ch.ready === 1'b1) begin
      if (awaited.size() == 0) begin
        note_mismatch("result with nothing awaited", fix_ch.range_mm, 0);
      end else begin
        want = awaited.pop_front();
        if (fix_ch.range_mm !== want.range_mm)
          note_mismatch("range_mm", fix_ch.range_mm, want.range_mm);
        if (fix_ch.track_angle !== want.track)
          note_mismatch("track_angle", fix_ch.track_angle, want.track);
        if (fix_ch.altitude_mm !== want.alt)
          note_mismatch("altitude_mm", fix_ch.altitude_mm, want.alt);
        checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, awaited.size());
      $display("baseline_range_and_bearing_core_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst              <= 1'b1;
    base_ch.valid    <= 1'b0;
    base_ch.east_mm  <= '0;
    base_ch.north_mm <= '0;
    base_ch.up_mm    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_corner_baselines();
    settle();
    test_full_scale();
    test_small_offsets();
    settle();
    test_axes_and_diagonals();
    test_back_to_back();
    test_mixed();
    settle();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (awaited.size() != 0) note_mismatch("results never delivered", awaited.size(), 0);
    $display("%0d baselines sent, %0d results checked, %0d zero baselines, %0d with -2^31",
             accepted, checked, zero_count, extreme_count);
    $display("traffic: back-to-back, bursty sender, random/periodic/choked receiver");
    if (errors == 0) begin
      $display("baseline_range_and_bearing_core_tb OK");
    end else begin
      $display("baseline_range_and_bearing_core_tb NOT OK");
    end
    $finish;
  end

endmodule
